@@ rtl/aessd_pkg.sv @@
package aessd_pkg;

  localparam int unsigned AES_ROUNDS_DEF = 14;
  localparam int unsigned BLOCK_BYTES    = 16;
  localparam int unsigned CFG_IDX_W      = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 8'd1;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_PAD = 2'd1;
  localparam logic [1:0] STATUS_TRUNC   = 2'd2;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic [4:0]  byte_count;
    logic        final_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic [4:0]  valid_bytes;
    logic        end_of_stream;
    logic [1:0]  status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic kx_init;
    logic kx_step;
    logic kx_save;
    logic load_held;
    logic load_cur;
    logic hold_cur;
    logic round;
    logic out_held;
    logic out_cur;
    logic out_trunc;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic held_valid;
    logic count_ok;
    logic final_block;
    logic last_round;
    logic kx_last;
    logic out_free;
  } ctrl_sts_t;

  // gf(2^8) helpers, used at elaboration to build the s-box tables
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] p;
    logic [7:0] e;
    r = 8'h01;
    p = a;
    e = 8'd254;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) r = gf_mul(r, p);
      p = gf_mul(p, p);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
    return 8'((x << n) | (x >> (8 - n)));
  endfunction

  function automatic logic [2047:0] gen_sbox();
    logic [2047:0] t;
    logic [7:0]    b;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      b = gf_inv(8'(i));
      t[i*8 +: 8] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    end
    return t;
  endfunction

  function automatic logic [2047:0] gen_isbox();
    logic [2047:0] t;
    logic [7:0]    y;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      y = 8'(i);
      t[i*8 +: 8] = gf_inv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
    end
    return t;
  endfunction

  localparam logic [2047:0] SBOX_TBL  = gen_sbox();
  localparam logic [2047:0] ISBOX_TBL = gen_isbox();

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_TBL[{x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] isbox(input logic [7:0] x);
    return ISBOX_TBL[{x, 3'b000} +: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [31:0] rot_word(input logic [31:0] w);
    return {w[23:0], w[31:24]};
  endfunction

  function automatic logic [7:0] rcon(input logic [2:0] idx);
    return 8'(8'h01 << idx);
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
  endfunction

  // inverse mix of one column, byte 0 in the top bits
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2;
    logic [7:0] x4;
    logic [7:0] x8;
    for (int i = 0; i < 4; i++) begin
      a[i]   = c[31-8*i -: 8];
      x2     = xtime(a[i]);
      x4     = xtime(x2);
      x8     = xtime(x4);
      m9[i]  = x8 ^ a[i];
      m11[i] = x8 ^ x2 ^ a[i];
      m13[i] = x8 ^ x4 ^ a[i];
      m14[i] = x8 ^ x4 ^ x2;
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

endpackage

@@ rtl/aes_stream_decrypt_pkcs7_trim.sv @@
// AES-256 ECB stream decryptor with PKCS#7 padding removal. Ciphertext comes in as one
// 16-byte block per item with a byte count and a final flag; the key is the 128-bit
// value in key_high/key_low used twice. Each full non-final block is held back, so an item
// gives zero, one or two result items: the held block as plain data, then on a final
// block the decrypted block with padding trimmed (or all 16 bytes and bad-padding status),
// or on a block whose count is not 16 a zero result with truncated status. One shared
// round unit does one AES round per cycle; a decrypt loads the block with the top round
// key, runs the rounds down to round 0 and then waits for the output register to be free.
// After reset and after every key write the key schedule is run forward once while no
// item is accepted; round keys are then rebuilt backward on the fly during each decrypt,
// so no round-key memory exists.
module aes_stream_decrypt_pkcs7_trim #(
  parameter int unsigned AES_ROUNDS = aessd_pkg::AES_ROUNDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // ciphertext items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  aessd_pkg::in_item_t             in_data_i,
  // plaintext items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output aessd_pkg::out_item_t            out_data_o,
  // key register writes, always taken
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [aessd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                     cfg_data_i
);

  aessd_pkg::ctrl_cmd_t cmd;
  aessd_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencing: key expansion, dispatch of held and new block, output slots
  aessd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  // key registers, key window, round unit, held block and output register
  aessd_datapath #(
    .AES_ROUNDS (AES_ROUNDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/aessd_ctrl.sv @@
module aessd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  cfg_valid_i,
  input  aessd_pkg::ctrl_sts_t  sts_i,
  output logic                  in_ready_o,
  output aessd_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_KINIT = 9'b000000001,
    S_KEXP  = 9'b000000010,
    S_IDLE  = 9'b000000100,
    S_DISP  = 9'b000001000,
    S_DECH  = 9'b000010000,
    S_OUTH  = 9'b000100000,
    S_DECC  = 9'b001000000,
    S_OUTC  = 9'b010000000,
    S_OUTT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && !cfg_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_KINIT: begin
        cmd_o.kx_init = 1'b1;
        state_d       = S_KEXP;
      end
      S_KEXP: begin
        cmd_o.kx_step = 1'b1;
        if (sts_i.kx_last) begin
          cmd_o.kx_save = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.held_valid) begin
          cmd_o.load_held = 1'b1;
          state_d         = S_DECH;
        end else if (!sts_i.count_ok) begin
          state_d = S_OUTT;
        end else if (!sts_i.final_block) begin
          cmd_o.hold_cur = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.load_cur = 1'b1;
          state_d        = S_DECC;
        end
      end
      S_DECH: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) state_d = S_OUTH;
      end
      S_OUTH: begin
        if (sts_i.out_free) begin
          cmd_o.out_held = 1'b1;
          state_d        = S_DISP;
        end
      end
      S_DECC: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) state_d = S_OUTC;
      end
      S_OUTC: begin
        if (sts_i.out_free) begin
          cmd_o.out_cur = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_OUTT: begin
        if (sts_i.out_free) begin
          cmd_o.out_trunc = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_KINIT;
    endcase
    // a key write restarts the expansion
    if (cfg_valid_i) begin
      cmd_o   = '0;
      state_d = S_KINIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_KINIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/aessd_datapath.sv @@
module aessd_datapath #(
  parameter int unsigned AES_ROUNDS = aessd_pkg::AES_ROUNDS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  aessd_pkg::in_item_t                in_data_i,
  input  logic                               cfg_we_i,
  input  logic [aessd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [63:0]                        cfg_data_i,
  input  aessd_pkg::ctrl_cmd_t               cmd_i,
  output aessd_pkg::ctrl_sts_t               sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output aessd_pkg::out_item_t               out_data_o
);

  localparam int unsigned RW = $clog2(AES_ROUNDS);
  localparam logic [RW-1:0] RND_TOP  = RW'(AES_ROUNDS - 1);
  localparam logic [RW-1:0] KX_LAST  = RW'(AES_ROUNDS - 2);

  logic [63:0]        key_hi_q, key_lo_q;
  logic [7:0][31:0]   win_q, win_d, last_win_q;
  logic [7:0][31:0]   win_fwd, win_back;
  logic [RW-1:0]      rnd_q;
  logic [127:0]       st_q, st_d;
  logic [127:0]       held_q, cur_q;
  logic               held_valid_q;
  logic               cur_count_ok_q, cur_final_q;
  logic [127:0]       rk_bottom, rk_top, round_out;
  logic [31:0]        t_fwd, t_back;
  logic [2:0]         rc_fwd, rc_back;
  logic [RW-1:0]      rnd_m1;
  logic               pad_ok;
  logic [4:0]         pad_valid;
  logic               out_valid_q;
  aessd_pkg::out_item_t out_q;

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = aessd_pkg::isbox(s[127 - 8*(r + 4*c) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    return {aessd_pkg::inv_mix_col(s[127:96]), aessd_pkg::inv_mix_col(s[95:64]),
            aessd_pkg::inv_mix_col(s[63:32]), aessd_pkg::inv_mix_col(s[31:0])};
  endfunction

  // forward key schedule step over an eight word window
  assign rc_fwd = 3'(rnd_q >> 1);
  assign t_fwd  = rnd_q[0] ? aessd_pkg::sub_word(win_q[7])
                           : aessd_pkg::sub_word(aessd_pkg::rot_word(win_q[7]))
                             ^ {aessd_pkg::rcon(rc_fwd), 24'h0};
  always_comb begin
    win_fwd[0] = win_q[4];
    win_fwd[1] = win_q[5];
    win_fwd[2] = win_q[6];
    win_fwd[3] = win_q[7];
    win_fwd[4] = win_q[0] ^ t_fwd;
    win_fwd[5] = win_q[1] ^ win_fwd[4];
    win_fwd[6] = win_q[2] ^ win_fwd[5];
    win_fwd[7] = win_q[3] ^ win_fwd[6];
  end

  // backward step, recovers the four words below the window
  assign rnd_m1  = rnd_q - 1'b1;
  assign rc_back = 3'(rnd_m1 >> 1);
  assign t_back  = rnd_q[0] ? aessd_pkg::sub_word(aessd_pkg::rot_word(win_q[3]))
                              ^ {aessd_pkg::rcon(rc_back), 24'h0}
                            : aessd_pkg::sub_word(win_q[3]);
  always_comb begin
    win_back[0] = win_q[4] ^ t_back;
    win_back[1] = win_q[5] ^ win_q[4];
    win_back[2] = win_q[6] ^ win_q[5];
    win_back[3] = win_q[7] ^ win_q[6];
    win_back[4] = win_q[0];
    win_back[5] = win_q[1];
    win_back[6] = win_q[2];
    win_back[7] = win_q[3];
  end

  assign rk_bottom = {win_q[0], win_q[1], win_q[2], win_q[3]};
  assign rk_top    = {last_win_q[4], last_win_q[5], last_win_q[6], last_win_q[7]};

  always_comb begin
    round_out = inv_shift_sub(st_q) ^ rk_bottom;
    if (rnd_q != '0) round_out = inv_mix(round_out);
  end

  always_comb begin
    win_d = win_q;
    st_d  = st_q;
    if (cmd_i.kx_init) begin
      win_d = {key_lo_q[31:0], key_lo_q[63:32], key_hi_q[31:0], key_hi_q[63:32],
               key_lo_q[31:0], key_lo_q[63:32], key_hi_q[31:0], key_hi_q[63:32]};
    end else if (cmd_i.kx_step) begin
      win_d = win_fwd;
    end else if (cmd_i.load_held || cmd_i.load_cur) begin
      win_d = last_win_q;
      st_d  = (cmd_i.load_held ? held_q : cur_q) ^ rk_top;
    end else if (cmd_i.round) begin
      win_d = win_back;
      st_d  = round_out;
    end
  end

  // padding check of the decrypted final block
  always_comb begin
    logic [7:0] pad;
    pad    = st_q[7:0];
    pad_ok = (pad >= 8'd1) && (pad <= 8'(aessd_pkg::BLOCK_BYTES));
    for (int i = 1; i < aessd_pkg::BLOCK_BYTES; i++) begin
      if ((8'(i) < pad) && (st_q[8*i +: 8] != pad)) pad_ok = 1'b0;
    end
    pad_valid = 5'(aessd_pkg::BLOCK_BYTES) - pad[4:0];
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    st_q  <= st_d;
    if (cmd_i.kx_save) last_win_q <= win_fwd;
    if (cmd_i.capture) begin
      cur_q          <= {in_data_i.cipher_high, in_data_i.cipher_low};
      cur_count_ok_q <= (in_data_i.byte_count == 5'(aessd_pkg::BLOCK_BYTES));
      cur_final_q    <= in_data_i.final_block;
    end
    if (cmd_i.hold_cur) held_q <= cur_q;
    if (cmd_i.out_held) begin
      out_q <= {st_q, 5'(aessd_pkg::BLOCK_BYTES), 1'b0, aessd_pkg::STATUS_OK};
    end else if (cmd_i.out_cur) begin
      out_q <= pad_ok ? {st_q, pad_valid, 1'b1, aessd_pkg::STATUS_OK}
                      : {st_q, 5'(aessd_pkg::BLOCK_BYTES), 1'b1, aessd_pkg::STATUS_BAD_PAD};
    end else if (cmd_i.out_trunc) begin
      out_q <= {128'h0, 5'd0, 1'b1, aessd_pkg::STATUS_TRUNC};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q     <= '0;
      key_lo_q     <= '0;
      rnd_q        <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == aessd_pkg::CFG_KEY_HIGH) key_hi_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == aessd_pkg::CFG_KEY_LOW)  key_lo_q <= cfg_data_i;
      if (cmd_i.kx_init) begin
        rnd_q <= '0;
      end else if (cmd_i.kx_step) begin
        rnd_q <= rnd_q + 1'b1;
      end else if (cmd_i.load_held || cmd_i.load_cur) begin
        rnd_q <= RND_TOP;
      end else if (cmd_i.round) begin
        rnd_q <= rnd_m1;
      end
      if (cmd_i.hold_cur) begin
        held_valid_q <= 1'b1;
      end else if (cmd_i.out_held) begin
        held_valid_q <= 1'b0;
      end
      if (cmd_i.out_held || cmd_i.out_cur || cmd_i.out_trunc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.held_valid  = held_valid_q;
  assign sts_o.count_ok    = cur_count_ok_q;
  assign sts_o.final_block = cur_final_q;
  assign sts_o.last_round  = (rnd_q == '0);
  assign sts_o.kx_last     = (rnd_q == KX_LAST);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sim/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles to let a block that is still decrypting go quiet before a key write
  localparam int DRAIN_CYCLES = 60;
  // cycles with no handshake at all before the run is declared hung
  localparam int HANG_LIMIT   = 6000;
  // receiver hold-off used to back the block up onto its input
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_ITEMS = 930;

  // how the final block of a stream gets its plaintext padding
  localparam int PAD_RAW  = 0;    // cipher bytes as given, padding is whatever falls out
  localparam int PAD_ZERO = -1;   // last plaintext byte zero
  localparam int PAD_BIG  = -2;   // last plaintext byte above the block size
  localparam int PAD_BENT = -3;   // pad length fine but one pad byte differs
  // key register index that decodes to nothing
  localparam logic [aessd_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hff;

  typedef struct {
    logic [127:0]         blk;
    logic [4:0]           cnt;
    bit                   fin;
    int                   pad;
    bit                   typed;
    aessd_pkg::out_item_t res;
  } row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  aessd_pkg::in_item_t             in_data_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  aessd_pkg::out_item_t            out_data_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [aessd_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [63:0]                     cfg_data_i = '0;

  aes_stream_decrypt_pkcs7_trim u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // own aes-256 arithmetic: s-boxes, key schedule, both directions
  // ---------------------------------------------------------------------------
  logic [7:0]  fwd_sbox [256];
  logic [7:0]  inv_sbox [256];
  logic [31:0] key_words [60];
  logic [63:0] key_hi_q, key_lo_q;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] x, int n);
    logic [15:0] d;
    d = {x, x} << n;
    return d[15:8];
  endfunction

  function automatic void build_sboxes();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      // x^254 is the field inverse, and maps zero to zero
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gmul(inv, 8'(x));
      s = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
      fwd_sbox[x] = s;
      inv_sbox[s] = 8'(x);
    end
  endfunction

  function automatic logic [31:0] sub4(logic [31:0] w);
    return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
  endfunction

  // 256-bit key is the 128-bit register pair written twice
  function automatic void load_key(logic [63:0] kh, logic [63:0] kl);
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++)
      key_words[i] = (i % 4 < 2) ? ((i % 2 == 0) ? kh[63:32] : kh[31:0])
                                 : ((i % 2 == 0) ? kl[63:32] : kl[31:0]);
    for (int i = 8; i < 60; i++) begin
      t = key_words[i-1];
      if (i % 8 == 0) begin
        t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end else if (i % 8 == 4) begin
        t = sub4(t);
      end
      key_words[i] = key_words[i-8] ^ t;
    end
  endfunction

  function automatic logic [127:0] rkey(int r);
    return {key_words[4*r], key_words[4*r+1], key_words[4*r+2], key_words[4*r+3]};
  endfunction

  // byte i of the block sits at bit 127-8i, row r of column c is byte 4c+r
  function automatic logic [127:0] shift_sub(logic [127:0] v, bit inverse);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inverse)
          t[127-8*(r+4*((c+r)%4)) -: 8] = inv_sbox[v[127-8*(r+4*c) -: 8]];
        else
          t[127-8*(r+4*c) -: 8] = fwd_sbox[v[127-8*(r+4*((c+r)%4)) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] v, bit inverse);
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      a0 = v[127-32*c -: 8];
      a1 = v[119-32*c -: 8];
      a2 = v[111-32*c -: 8];
      a3 = v[103-32*c -: 8];
      if (inverse)
        t[127-32*c -: 32] = {
          gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9),
          gmul(a0, 8'd9)  ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13),
          gmul(a0, 8'd13) ^ gmul(a1, 8'd9)  ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11),
          gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9)  ^ gmul(a3, 8'd14)};
      else
        t[127-32*c -: 32] = {
          gmul(a0, 8'd2) ^ gmul(a1, 8'd3) ^ a2 ^ a3,
          a0 ^ gmul(a1, 8'd2) ^ gmul(a2, 8'd3) ^ a3,
          a0 ^ a1 ^ gmul(a2, 8'd2) ^ gmul(a3, 8'd3),
          gmul(a0, 8'd3) ^ a1 ^ a2 ^ gmul(a3, 8'd2)};
    end
    return t;
  endfunction

  function automatic logic [127:0] aes_decrypt(logic [127:0] v);
    v ^= rkey(aessd_pkg::AES_ROUNDS_DEF);
    for (int r = aessd_pkg::AES_ROUNDS_DEF - 1; r >= 1; r--)
      v = mix_cols(shift_sub(v, 1'b1) ^ rkey(r), 1'b1);
    return shift_sub(v, 1'b1) ^ rkey(0);
  endfunction

  // used only to build ciphertext whose plaintext carries chosen padding
  function automatic logic [127:0] aes_encrypt(logic [127:0] v);
    v ^= rkey(0);
    for (int r = 1; r < aessd_pkg::AES_ROUNDS_DEF; r++)
      v = mix_cols(shift_sub(v, 1'b0), 1'b0) ^ rkey(r);
    return shift_sub(v, 1'b0) ^ rkey(aessd_pkg::AES_ROUNDS_DEF);
  endfunction

  function automatic logic [127:0] padded_cipher(int pad);
    logic [127:0] pt;
    int p;
    pt = {$urandom, $urandom, $urandom, $urandom};
    if (pad >= 1 && pad <= 16) begin
      for (int i = 0; i < pad; i++) pt[8*i +: 8] = 8'(pad);
    end else if (pad == PAD_ZERO) begin
      pt[7:0] = 8'h00;
    end else if (pad == PAD_BIG) begin
      pt[7:0] = 8'($urandom_range(255, 17));
    end else if (pad == PAD_BENT) begin
      p = $urandom_range(16, 2);
      for (int i = 0; i < p; i++) pt[8*i +: 8] = 8'(p);
      pt[8*$urandom_range(p-1, 1) +: 8] ^= 8'($urandom_range(255, 1));
    end else begin
      return pt;
    end
    return aes_encrypt(pt);
  endfunction

  // ---------------------------------------------------------------------------
  // stream predictor: held block plus expected plaintext items
  // ---------------------------------------------------------------------------
  aessd_pkg::out_item_t plain_q [$];
  bit                   held_q;
  logic [127:0]         held_blk;
  int                   errors;

  function automatic void predict_plain(aessd_pkg::in_item_t it, bit keep);
    logic [127:0] p;
    logic [7:0]   pad;
    bit           ok;
    if (held_q) begin
      p = aes_decrypt(held_blk);
      if (keep) plain_q.push_back('{p[127:64], p[63:0], 5'd16, 1'b0, aessd_pkg::STATUS_OK});
      held_q = 1'b0;
    end
    // any byte count but a whole block ends the stream
    if (it.byte_count != 5'd16) begin
      if (keep) plain_q.push_back('{64'h0, 64'h0, 5'd0, 1'b1, aessd_pkg::STATUS_TRUNC});
      return;
    end
    if (!it.final_block) begin
      held_blk = {it.cipher_high, it.cipher_low};
      held_q = 1'b1;
      return;
    end
    p   = aes_decrypt({it.cipher_high, it.cipher_low});
    pad = p[7:0];
    ok  = (pad >= 1 && pad <= 16);
    for (int i = 1; i < 16; i++)
      if (ok && i < pad && p[8*i +: 8] != pad) ok = 1'b0;
    if (keep)
      plain_q.push_back(ok ? '{p[127:64], p[63:0], 5'(16 - pad), 1'b1, aessd_pkg::STATUS_OK}
                           : '{p[127:64], p[63:0], 5'd16, 1'b1, aessd_pkg::STATUS_BAD_PAD});
  endfunction

  // ---------------------------------------------------------------------------
  // idling knobs, shared by sender and receiver
  // ---------------------------------------------------------------------------
  int send_idle_pct, recv_stall_pct;
  bit holdoff_req;

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        hold = HOLDOFF_CYCLES;
        holdoff_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker, sampled on the rising edge
  always @(posedge clk_i) begin
    aessd_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (plain_q.size() == 0) begin
        $error("unexpected item: %h", out_data_o);
        errors++;
      end else begin
        want = plain_q.pop_front();
        if (out_data_o.plain_high !== want.plain_high) begin
          $error("plain_high want %h got %h", want.plain_high, out_data_o.plain_high);
          errors++;
        end
        if (out_data_o.plain_low !== want.plain_low) begin
          $error("plain_low want %h got %h", want.plain_low, out_data_o.plain_low);
          errors++;
        end
        if (out_data_o.valid_bytes !== want.valid_bytes) begin
          $error("valid_bytes want %0d got %0d", want.valid_bytes, out_data_o.valid_bytes);
          errors++;
        end
        if (out_data_o.end_of_stream !== want.end_of_stream) begin
          $error("end_of_stream want %0d got %0d", want.end_of_stream,
                 out_data_o.end_of_stream);
          errors++;
        end
        if (out_data_o.status !== want.status) begin
          $error("status want %0d got %0d", want.status, out_data_o.status);
          errors++;
        end
      end
    end
  end

  // hang detector: any handshake on any channel resets it
  always @(posedge clk_i) begin
    int quiet;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == HANG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  task automatic send_block(logic [127:0] blk, logic [4:0] cnt, bit fin,
                            bit typed = 1'b0, aessd_pkg::out_item_t res = '0);
    aessd_pkg::in_item_t it;
    it = '{blk[127:64], blk[63:0], cnt, fin};
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    // predictor always tracks the held block; typed rows supply the item themselves
    predict_plain(it, !typed);
    if (typed) plain_q.push_back(res);
  endtask

  task automatic wait_drained();
    while (plain_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_key(logic [aessd_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == aessd_pkg::CFG_KEY_HIGH) key_hi_q = val;
    if (idx == aessd_pkg::CFG_KEY_LOW)  key_lo_q = val;
    load_key(key_hi_q, key_lo_q);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed streams with random content, the rest noise
  task automatic random_items(int n);
    int sent, len, kind, pad;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(99) < 70) ? $urandom_range(2, 0) : $urandom_range(6, 3);
        for (int i = 0; i < len; i++)
          send_block({$urandom, $urandom, $urandom, $urandom}, 5'd16, 1'b0);
        kind = $urandom_range(99);
        if (kind < 6) begin
          // stream cut short by a partial block
          send_block({$urandom, $urandom, $urandom, $urandom},
                     5'($urandom_range(15, 0)), 1'($urandom));
        end else begin
          if (kind < 78)      pad = $urandom_range(16, 1);
          else if (kind < 84) pad = PAD_ZERO;
          else if (kind < 90) pad = PAD_BIG;
          else if (kind < 96) pad = PAD_BENT;
          else                pad = PAD_RAW;
          send_block(padded_cipher(pad), 5'd16, 1'b1);
        end
        sent += len + 1;
      end else begin
        send_block({$urandom, $urandom, $urandom, $urandom},
                   ($urandom_range(1) != 0) ? 5'd16 : 5'($urandom_range(31, 0)),
                   1'($urandom));
        sent++;
      end
    end
  endtask

  // directed rows; only single-item results with nothing held are typed in
  localparam aessd_pkg::out_item_t TRUNC_ITEM = '{64'h0, 64'h0, 5'd0, 1'b1,
                                                  aessd_pkg::STATUS_TRUNC};
  localparam logic [127:0] ONES = {128{1'b1}};

  row_t rows [] = '{
    '{128'h0, 5'd0,  1'b0, PAD_RAW,  1'b1, TRUNC_ITEM},  // empty block, no stream
    '{ONES,   5'd31, 1'b1, PAD_RAW,  1'b1, TRUNC_ITEM},  // count field at top
    '{ONES,   5'd16, 1'b0, PAD_RAW,  1'b0, '0},          // hold all-ones
    '{128'h0, 5'd16, 1'b1, PAD_RAW,  1'b0, '0},          // final behind held
    '{128'h0, 5'd16, 1'b1, 16,       1'b0, '0},          // whole block of padding
    '{128'h0, 5'd16, 1'b1, 1,        1'b0, '0},          // single pad byte
    '{ONES,   5'd16, 1'b0, PAD_RAW,  1'b0, '0},
    '{128'h0, 5'd17, 1'b0, PAD_RAW,  1'b0, '0},          // over-long count cuts held
    '{128'h0, 5'd15, 1'b1, PAD_RAW,  1'b1, TRUNC_ITEM},
    '{128'h0, 5'd1,  1'b0, PAD_RAW,  1'b1, TRUNC_ITEM},
    '{128'h0123456789abcdef_fedcba9876543210, 5'd16, 1'b0, PAD_RAW, 1'b0, '0},
    '{128'h00112233445566778899aabbccddeeff,  5'd16, 1'b0, PAD_RAW, 1'b0, '0},
    '{128'h0, 5'd16, 1'b1, 8,        1'b0, '0},
    '{128'h0, 5'd16, 1'b1, PAD_ZERO, 1'b0, '0},          // pad byte zero
    '{128'h0, 5'd16, 1'b1, PAD_BIG,  1'b0, '0},          // pad byte past block size
    '{128'h0, 5'd16, 1'b1, PAD_BENT, 1'b0, '0},          // one pad byte off
    '{128'h0, 5'd16, 1'b0, PAD_RAW,  1'b0, '0},
    '{128'h0, 5'd0,  1'b1, PAD_RAW,  1'b0, '0},          // empty final behind held
    '{128'h0, 5'd16, 1'b1, 15,       1'b0, '0},
    '{128'h0, 5'd8,  1'b0, PAD_RAW,  1'b1, TRUNC_ITEM},
    '{128'h0, 5'd16, 1'b1, 2,        1'b0, '0}
  };

  initial begin
    logic [127:0] blk;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_req = 1'b0;
    held_q = 1'b0;
    held_blk = '0;
    key_hi_q = '0;
    key_lo_q = '0;
    build_sboxes();
    load_key(key_hi_q, key_lo_q);
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset key
    foreach (rows[i]) begin
      blk = (rows[i].pad == PAD_RAW) ? rows[i].blk : padded_cipher(rows[i].pad);
      send_block(blk, rows[i].cnt, rows[i].fin, rows[i].typed, rows[i].res);
    end

    // four phases of idling, each behind fresh keys
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      case (ph)
        0: begin
          write_key(aessd_pkg::CFG_KEY_HIGH, {64{1'b1}});
          write_key(aessd_pkg::CFG_KEY_LOW, {64{1'b1}});
          write_key(CFG_IDX_UNUSED, {$urandom, $urandom});
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          write_key(aessd_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
          write_key(aessd_pkg::CFG_KEY_LOW, {$urandom, $urandom});
          send_idle_pct = 81; recv_stall_pct = 0;
        end
        2: begin
          write_key(aessd_pkg::CFG_KEY_HIGH, 64'h0);
          write_key(aessd_pkg::CFG_KEY_LOW, 64'h0);
          send_idle_pct = 0;  recv_stall_pct = 81;
        end
        default: begin
          write_key(aessd_pkg::CFG_KEY_LOW, {$urandom, $urandom});
          write_key(aessd_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
          send_idle_pct = 32; recv_stall_pct = 32;
        end
      endcase
      random_items(RANDOM_ITEMS / 8);
      if (ph == 0) holdoff_req = 1'b1;  // receiver backs up while items keep coming
      if (ph == 2) begin
        // sender pauses until every outstanding item has come back
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        wait_drained();
      end
      random_items(RANDOM_ITEMS / 8);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && plain_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
